// File: rtl/core/intel_hex_record_reader_macros.svh
// Assertion macros used by the port-level checker of the Intel HEX record reader.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef INTEL_HEX_RECORD_READER_MACROS_SVH
`define INTEL_HEX_RECORD_READER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define IHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ihr_pkg.sv
// Shared types, constants and the hex digit decoder of the Intel HEX record reader.
// Depends on nothing; every other file of the block but the macro header uses it.
`timescale 1ns / 1ps
`default_nettype none

package ihr_pkg;

  localparam int MAX_LINE = 256;
  localparam int POS_W    = $clog2(MAX_LINE);
  localparam int IDX_W    = 9;

  localparam logic [7:0]  LINE_FEED = 8'h0A;
  localparam logic [7:0]  COLON     = 8'h3A;
  localparam int          MIN_LINE  = 11;
  localparam logic [16:0] NO_DATA   = 17'h10000;
  localparam logic [4:0]  BAD_DIGIT = 5'd16;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_FORMAT   = 2'd2,
    KIND_CHECKSUM = 2'd3
  } kind_t;

  // One result on its way from the parser to the output stage.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [16:0] start_address;
    logic [16:0] highest_end;
  } result_t;

  typedef struct packed {
    logic format;
    logic skip;
    logic digit;
  } line_flags_t;

  // ASCII hex digit to value; BAD_DIGIT for anything that is not a digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    begin
      v = BAD_DIGIT;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        v = {1'b0, 4'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        v = {1'b0, 4'(c - 8'h61 + 8'd10)};
      end
      return v;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ihr_front.sv
// Character parser of the Intel HEX record reader: line state, checks and result items.
// Depends on ihr_pkg; pushes its results into ihr_queue.
`timescale 1ns / 1ps
`default_nettype none

module ihr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      ch,
  input  wire logic            end_of_file,
  input  wire logic            q_full,
  output logic                 push,
  output ihr_pkg::result_t     push_entry
);

  logic [ihr_pkg::POS_W-1:0] line_position, line_position_next;
  logic [3:0]                high_nibble, high_nibble_next;
  logic [7:0]                byte_count, byte_count_next;
  logic [15:0]               record_address, record_address_next;
  logic [7:0]                running_sum, running_sum_next;
  logic [ihr_pkg::IDX_W-1:0] data_index, data_index_next;
  logic [16:0]               lowest_start, lowest_start_next;
  logic [16:0]               highest_end, highest_end_next;
  ihr_pkg::line_flags_t      line_flags, line_flags_next;
  logic                      failed, failed_next;

  logic                      accept;
  logic [4:0]                v;
  logic [7:0]                b;
  logic [16:0]               rec_end;
  logic [ihr_pkg::IDX_W-1:0] count_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    line_position_next  = line_position;
    high_nibble_next    = high_nibble;
    byte_count_next     = byte_count;
    record_address_next = record_address;
    running_sum_next    = running_sum;
    data_index_next     = data_index;
    lowest_start_next   = lowest_start;
    highest_end_next    = highest_end;
    line_flags_next     = line_flags;
    failed_next         = failed;
    push                = 1'b0;
    push_entry          = '0;

    v         = ihr_pkg::hex_value(ch);
    b         = {high_nibble, v[3:0]};
    rec_end   = {1'b0, record_address} + {9'd0, byte_count};
    count_ext = {1'b0, byte_count};

    if (accept) begin
      if (end_of_file) begin
        if (!failed) begin
          push                     = 1'b1;
          push_entry.kind          = ihr_pkg::KIND_DONE;
          push_entry.start_address = lowest_start;
          push_entry.highest_end   = highest_end;
        end
        line_position_next  = '0;
        high_nibble_next    = '0;
        byte_count_next     = '0;
        record_address_next = '0;
        running_sum_next    = '0;
        data_index_next     = '0;
        line_flags_next     = '0;
        lowest_start_next   = ihr_pkg::NO_DATA;
        highest_end_next    = '0;
        failed_next         = 1'b0;
      end else if (!failed) begin
        if (ch == ihr_pkg::LINE_FEED) begin
          if (line_position < ihr_pkg::POS_W'(ihr_pkg::MIN_LINE) || line_flags.format) begin
            failed_next     = 1'b1;
            push            = 1'b1;
            push_entry.kind = ihr_pkg::KIND_FORMAT;
          end else if (!line_flags.skip) begin
            if ({1'b0, record_address} < lowest_start) begin
              lowest_start_next = {1'b0, record_address};
            end
            if (rec_end > highest_end) begin
              highest_end_next = rec_end;
            end
            if (line_flags.digit || data_index <= count_ext || running_sum != 8'd0) begin
              failed_next     = 1'b1;
              push            = 1'b1;
              push_entry.kind = ihr_pkg::KIND_CHECKSUM;
            end
          end
          line_position_next  = '0;
          high_nibble_next    = '0;
          byte_count_next     = '0;
          record_address_next = '0;
          running_sum_next    = '0;
          data_index_next     = '0;
          line_flags_next     = '0;
        end else if (line_position >= ihr_pkg::POS_W'(ihr_pkg::MAX_LINE - 1)) begin
          line_flags_next.format = 1'b1;
        end else begin
          line_position_next = line_position + 1'b1;
          if (line_position == '0) begin
            if (ch != ihr_pkg::COLON) begin
              line_flags_next.format = 1'b1;
            end
          end else if (line_position <= ihr_pkg::POS_W'(8)) begin
            // Header: length and type two digits each, address four digits.
            if (v[4]) begin
              line_flags_next.skip = 1'b1;
            end else if (line_position[0]) begin
              high_nibble_next = v[3:0];
            end else begin
              running_sum_next = running_sum + b;
              if (line_position == ihr_pkg::POS_W'(2)) begin
                byte_count_next = b;
              end else if (line_position == ihr_pkg::POS_W'(4)) begin
                record_address_next = {b, 8'd0};
              end else if (line_position == ihr_pkg::POS_W'(6)) begin
                record_address_next = {record_address[15:8], b};
              end else if (b != 8'd0) begin
                line_flags_next.skip = 1'b1;
              end
            end
          end else if (!(line_flags.skip || line_flags.format || line_flags.digit) &&
                       data_index <= count_ext) begin
            // Data bytes, then the checksum byte.
            if (v[4]) begin
              line_flags_next.digit = 1'b1;
            end else if (line_position[0]) begin
              high_nibble_next = v[3:0];
            end else begin
              running_sum_next = running_sum + b;
              data_index_next  = data_index + 1'b1;
              if (data_index < count_ext) begin
                push               = 1'b1;
                push_entry.kind    = ihr_pkg::KIND_DATA;
                push_entry.address = record_address + {8'd0, data_index[7:0]};
                push_entry.data    = b;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position  <= '0;
      high_nibble    <= '0;
      byte_count     <= '0;
      record_address <= '0;
      running_sum    <= '0;
      data_index     <= '0;
      lowest_start   <= ihr_pkg::NO_DATA;
      highest_end    <= '0;
      line_flags     <= '0;
      failed         <= 1'b0;
    end else begin
      line_position  <= line_position_next;
      high_nibble    <= high_nibble_next;
      byte_count     <= byte_count_next;
      record_address <= record_address_next;
      running_sum    <= running_sum_next;
      data_index     <= data_index_next;
      lowest_start   <= lowest_start_next;
      highest_end    <= highest_end_next;
      line_flags     <= line_flags_next;
      failed         <= failed_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ihr_queue.sv
// Two-entry result queue between the parser and the output stage.
// Depends on ihr_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module ihr_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ihr_pkg::result_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output ihr_pkg::result_t       head
);

  ihr_pkg::result_t entries [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ihr_back.sv
// Output stage of the Intel HEX record reader: takes queued results, works out the
// span of a done report and holds the result until the consumer takes it. Uses ihr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihr_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire ihr_pkg::result_t  q_head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             kind,
  output logic [15:0]            address,
  output logic [7:0]             data,
  output logic [16:0]            start_address,
  output logic [16:0]            length
);

  logic        load;
  logic [16:0] span;

  assign load = q_valid && (!out_valid || out_ready);
  assign pop  = load;

  // Span is zero but for a done report whose highest end lies above its lowest start.
  always_comb begin
    span = '0;
    if (q_head.kind == ihr_pkg::KIND_DONE && q_head.highest_end > q_head.start_address) begin
      span = q_head.highest_end - q_head.start_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind          <= q_head.kind;
      address       <= q_head.address;
      data          <= q_head.data;
      start_address <= q_head.start_address;
      length        <= span;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/intel_hex_record_reader.sv
// Intel HEX record reader, top level: ihr_front, ihr_queue and ihr_back; uses ihr_pkg.
// Throughput: one character per cycle while the result queue is not full (in_ready).
// Path of a result: the result of a transferred character is written into the result
// queue, then loaded into the output register, where it is held while the consumer stalls.
// Reset (rst, synchronous): line state cleared, no data seen, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_reader (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  ch,
  input  wire logic        end_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [15:0]      address,
  output logic [7:0]       data,
  output logic [16:0]      start_address,
  output logic [16:0]      length
);

  // The parser takes a character whenever the queue has room. Each character gives at
  // most one result, so a two-entry queue keeps one transfer per cycle going while the
  // output register may hold a result the consumer has not yet taken.
  logic             q_full;
  logic             q_push;
  ihr_pkg::result_t q_push_entry;
  logic             q_pop;
  logic             q_valid;
  ihr_pkg::result_t q_head;

  // Front: line position, header decode, checksum, data byte writes, and the file-level
  // lowest start and highest end. Errors stop parsing until end of file.
  ihr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .end_of_file(end_of_file),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  ihr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Back: the span subtraction of a done report and the output register.
  ihr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .address      (address),
    .data         (data),
    .start_address(start_address),
    .length       (length)
  );

endmodule

`default_nettype wire

// File: rtl/core/ihr_checker.sv
// Port-level checks of the Intel HEX record reader, bound to the top level.
// Depends on ihr_pkg and intel_hex_record_reader_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "intel_hex_record_reader_macros.svh"

module ihr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [16:0] start_address,
  input wire logic [16:0] length
);

  `IHR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind), "result dropped or changed while stalled")
  `IHR_ASSERT_NOW(a_data_no_span, out_valid && kind == ihr_pkg::KIND_DATA, start_address == 17'd0 && length == 17'd0, "data write carries done fields")
  `IHR_ASSERT_NOW(a_done_start, out_valid && kind == ihr_pkg::KIND_DONE, start_address <= ihr_pkg::NO_DATA, "done start beyond no-data mark")
  `IHR_ASSERT_NOW(a_done_empty, out_valid && kind == ihr_pkg::KIND_DONE && start_address == ihr_pkg::NO_DATA, length == 17'd0, "empty file reports a span")

endmodule

bind intel_hex_record_reader ihr_checker u_ihr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .start_address(start_address),
  .length       (length)
);

`default_nettype wire

// File: tb/sv/intel_hex_record_reader_checker.sv
// Checker for the Intel HEX record reader: watches both channels, predicts each result
// from the accepted characters and compares it with what the block delivers.
// Depends on ihr_pkg for the result kinds and the parser constants.
`timescale 1ns / 1ps

module intel_hex_record_reader_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  ch,
  input  wire logic        end_of_file,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  input  wire logic [16:0] start_address,
  input  wire logic [16:0] length,
  output int               errors,
  output int               outstanding
);

  typedef struct packed {
    ihr_pkg::kind_t kind;
    logic [15:0]    address;
    logic [7:0]     data;
    logic [16:0]    start_address;
    logic [16:0]    length;
  } hex_result_t;

  hex_result_t expected_results[$];
  int          fail_count = 0;

  // Parser state, one copy per file in progress.
  logic [8:0]  line_pos;
  logic [3:0]  nibble_hi;
  logic [7:0]  rec_len;
  logic [15:0] rec_addr;
  logic [7:0]  rec_sum;
  logic [8:0]  bytes_seen;
  logic [16:0] low_start;
  logic [16:0] high_end;
  logic        bad_format;
  logic        skip_rec;
  logic        bad_digit;
  logic        file_failed;

  assign errors = fail_count;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b0, 4'(c[3:0] + 4'd9)};
    return 5'd16;
  endfunction

  task automatic clear_line();
    line_pos   = '0;
    nibble_hi  = '0;
    rec_len    = '0;
    rec_addr   = '0;
    rec_sum    = '0;
    bytes_seen = '0;
    bad_format = 1'b0;
    skip_rec   = 1'b0;
    bad_digit  = 1'b0;
  endtask

  task automatic clear_file();
    clear_line();
    low_start   = ihr_pkg::NO_DATA;
    high_end    = '0;
    file_failed = 1'b0;
  endtask

  // Line feed: format check, then span update and checksum check for data records.
  task automatic close_line(output logic hit, output hex_result_t r);
    logic [16:0] rec_end;
    hit = 1'b0;
    r   = '0;
    if (line_pos < ihr_pkg::MIN_LINE || bad_format) begin
      file_failed = 1'b1;
      hit         = 1'b1;
      r.kind      = ihr_pkg::KIND_FORMAT;
    end else if (!skip_rec) begin
      rec_end = {1'b0, rec_addr} + 17'(rec_len);
      if ({1'b0, rec_addr} < low_start) low_start = {1'b0, rec_addr};
      if (rec_end > high_end) high_end = rec_end;
      if (bad_digit || bytes_seen <= {1'b0, rec_len} || rec_sum != 8'd0) begin
        file_failed = 1'b1;
        hit         = 1'b1;
        r.kind      = ihr_pkg::KIND_CHECKSUM;
      end
    end
    clear_line();
  endtask

  task automatic take_char(input logic [7:0] c, output logic hit, output hex_result_t r);
    logic [8:0] p;
    logic [4:0] v;
    logic [7:0] b;
    hit = 1'b0;
    r   = '0;
    if (line_pos >= 9'(ihr_pkg::MAX_LINE - 1)) begin
      bad_format = 1'b1;
      return;
    end
    p        = line_pos;
    line_pos = p + 9'd1;
    if (p == 9'd0) begin
      if (c != ihr_pkg::COLON) bad_format = 1'b1;
      return;
    end
    v = nibble_of(c);
    if (p <= 9'd8) begin
      // Header: length, address and type.
      if (v[4]) begin
        skip_rec = 1'b1;
        return;
      end
      if (p[0]) begin
        nibble_hi = v[3:0];
        return;
      end
      b = {nibble_hi, v[3:0]};
      rec_sum += b;
      case (p)
        9'd2: rec_len = b;
        9'd4: rec_addr = {b, 8'h00};
        9'd6: rec_addr[7:0] = rec_addr[7:0] | b;
        default: begin
          if (b != 8'd0) skip_rec = 1'b1;
        end
      endcase
      return;
    end
    if (bad_format || skip_rec || bad_digit) return;
    if (bytes_seen > {1'b0, rec_len}) return;
    if (v[4]) begin
      bad_digit = 1'b1;
      return;
    end
    if (p[0]) begin
      nibble_hi = v[3:0];
      return;
    end
    b = {nibble_hi, v[3:0]};
    rec_sum += b;
    if (bytes_seen < {1'b0, rec_len}) begin
      hit       = 1'b1;
      r.kind    = ihr_pkg::KIND_DATA;
      r.address = rec_addr + 16'(bytes_seen);
      r.data    = b;
    end
    bytes_seen = bytes_seen + 9'd1;
  endtask

  task automatic parse_item(input logic [7:0] c, input logic eof,
                            output logic hit, output hex_result_t r);
    hit = 1'b0;
    r   = '0;
    if (eof) begin
      if (!file_failed) begin
        hit             = 1'b1;
        r.kind          = ihr_pkg::KIND_DONE;
        r.start_address = low_start;
        r.length        = (high_end > low_start) ? high_end - low_start : 17'd0;
      end
      clear_file();
    end else if (!file_failed) begin
      if (c == ihr_pkg::LINE_FEED) close_line(hit, r);
      else take_char(c, hit, r);
    end
  endtask

  always @(posedge clk) begin
    hex_result_t want;
    hex_result_t seen;
    logic        hit;
    if (rst) begin
      clear_file();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen.kind          = ihr_pkg::kind_t'(kind);
        seen.address       = address;
        seen.data          = data;
        seen.start_address = start_address;
        seen.length        = length;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result: kind %0d address %h data %h start %h length %h",
                     kind, address, data, start_address, length);
          end
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (seen.kind !== want.kind || seen.address !== want.address ||
              seen.data !== want.data || seen.start_address !== want.start_address ||
              seen.length !== want.length) begin
            if (fail_count < 10) begin
              $display({"result mismatch: expected kind %0d address %h data %h start %h ",
                        "length %h, got kind %0d address %h data %h start %h length %h"},
                       want.kind, want.address, want.data, want.start_address, want.length,
                       kind, address, data, start_address, length);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        parse_item(ch, end_of_file, hit, want);
        if (hit) expected_results.push_back(want);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// File: tb/sv/intel_hex_record_reader_tb.sv
// Testbench top for the Intel HEX record reader: clock, reset, character stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on ihr_pkg, intel_hex_record_reader and intel_hex_record_reader_checker.
`timescale 1ns / 1ps

module intel_hex_record_reader_tb;

  // Stimulus stops once this many characters have been transferred.
  localparam int ITEM_TARGET    = 900;
  // Cycles without any transfer on either channel before the run is abandoned.
  // The long receiver hold-off below is the longest legitimate quiet stretch.
  localparam int QUIET_LIMIT    = 3000;
  localparam int SQUEEZE_CYCLES = 400;

  // Ways in which a generated record can be damaged.
  typedef enum int {
    FLAW_NONE,
    FLAW_START,
    FLAW_DIGIT,
    FLAW_CUT,
    FLAW_SUM,
    FLAW_TAIL,
    FLAW_LONG,
    FLAW_SHORT
  } flaw_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  ch;
  logic        end_of_file;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [7:0]  data;
  logic [16:0] start_address;
  logic [16:0] length;

  int mismatches;
  int outstanding;
  int items_sent;
  int quiet_cycles;
  int files_sent;
  bit sender_gaps;
  bit receiver_gaps;
  bit squeeze_request;

  // Characters of the line being built, colon included, line feed not.
  logic [7:0] line_buf[$];

  intel_hex_record_reader dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ch            (ch),
    .end_of_file   (end_of_file),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .address       (address),
    .data          (data),
    .start_address (start_address),
    .length        (length)
  );

  intel_hex_record_reader_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ch            (ch),
    .end_of_file   (end_of_file),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .address       (address),
    .data          (data),
    .start_address (start_address),
    .length        (length),
    .errors        (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. It normally takes every result, stalls in short random bursts while
  // receiver_gaps is set, and once holds off for a long stretch on request so that
  // the result queue fills and the block has to stop taking characters.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_request) begin
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        squeeze_request = 1'b0;
        out_ready <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one character and returns at the falling edge after its transfer. Valid
  // is left high with the old payload; the caller either offers the next character
  // at once or lowers valid, both in this same step.
  task automatic send_item(input logic [7:0] c, input logic eof);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    ch          <= c;
    end_of_file <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_line(input bit terminate);
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    if (terminate) send_item(ihr_pkg::LINE_FEED, 1'b0);
  endtask

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Hex digit in random letter case, so both cases of A to F get exercised.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  // Any byte except a line feed; covers the high half of the character range.
  function automatic logic [7:0] any_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == ihr_pkg::LINE_FEED) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // A byte that is neither a hex digit, a colon nor a line feed.
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = any_char();
    while (is_hex_char(c) || c == ihr_pkg::COLON) c = any_char();
    return c;
  endfunction

  // Mostly short records keep lines brief; a few long ones run past the line limit.
  function automatic int pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(0, 6);
    if (roll < 97) return $urandom_range(7, 40);
    return $urandom_range(100, 255);
  endfunction

  function automatic logic [7:0] pick_type();
    if ($urandom_range(0, 9) < 8) return 8'h00;
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(1, 5));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic flaw_t pick_flaw();
    if ($urandom_range(0, 99) < 85) return FLAW_NONE;
    return flaw_t'($urandom_range(1, 7));
  endfunction

  // Builds one record into line_buf with a correct checksum, then damages it as asked.
  // A length below zero picks a random one.
  task automatic build_record(input logic [7:0] rtype, input int len, input flaw_t flaw);
    logic [7:0]  fields[$];
    logic [7:0]  total;
    logic [15:0] base;
    int          n;
    int          target;
    n = (len >= 0) ? len : pick_length();
    // Some records sit at the top of the address space so that addresses wrap.
    if ($urandom_range(0, 4) == 0) base = 16'hFFFF - 16'($urandom_range(0, 8));
    else base = 16'($urandom_range(0, 65535));
    fields.push_back(8'(n));
    fields.push_back(base[15:8]);
    fields.push_back(base[7:0]);
    fields.push_back(rtype);
    repeat (n) fields.push_back(8'($urandom_range(0, 255)));
    total = 8'd0;
    foreach (fields[i]) total += fields[i];
    if (flaw == FLAW_SUM) total += 8'($urandom_range(1, 255));
    fields.push_back(8'd0 - total);
    line_buf.delete();
    line_buf.push_back(ihr_pkg::COLON);
    foreach (fields[i]) begin
      line_buf.push_back(hex_char(fields[i][7:4]));
      line_buf.push_back(hex_char(fields[i][3:0]));
    end
    case (flaw)
      FLAW_START: line_buf[0] = junk_char();
      FLAW_DIGIT: line_buf[$urandom_range(1, line_buf.size() - 1)] = junk_char();
      // Drop one or both checksum digits.
      FLAW_CUT: repeat ($urandom_range(1, 2)) void'(line_buf.pop_back());
      // Trailing characters after the checksum are ignored by the block.
      FLAW_TAIL: repeat ($urandom_range(1, 6)) line_buf.push_back(any_char());
      FLAW_LONG: begin
        target = $urandom_range(ihr_pkg::MAX_LINE, ihr_pkg::MAX_LINE + 44);
        while (line_buf.size() < target) line_buf.push_back(any_char());
      end
      FLAW_SHORT: begin
        target = $urandom_range(0, ihr_pkg::MIN_LINE - 1);
        while (line_buf.size() > target) void'(line_buf.pop_back());
      end
      default: ;
    endcase
  endtask

  // One file: a few records, sometimes an unterminated last line, then end of file.
  // The character offered with end of file is random since the block ignores it.
  task automatic send_file();
    int keep;
    repeat ($urandom_range(0, 4)) begin
      build_record(pick_type(), -1, pick_flaw());
      send_line(1'b1);
    end
    if ($urandom_range(0, 7) == 0) begin
      build_record(pick_type(), -1, FLAW_NONE);
      keep = $urandom_range(0, line_buf.size());
      while (line_buf.size() > keep) void'(line_buf.pop_back());
      send_line(1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
    files_sent++;
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    ch              = 8'h00;
    end_of_file     = 1'b0;
    sender_gaps     = 1'b0;
    receiver_gaps   = 1'b0;
    squeeze_request = 1'b0;
    items_sent      = 0;
    files_sent      = 0;
    quiet_cycles    = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // An empty file reports no data: start 65536, length 0.
    send_item(8'h00, 1'b1);
    // A two-byte data record at the very top of memory: the second byte's address
    // wraps to zero, while the span still counts the full end address.
    send_text(":02FFff00fF0001\n");
    send_item(8'hFF, 1'b1);
    // A zero-length data record with a wrong checksum fails the file, so the end
    // of file that follows gives no result.
    send_text(":0000000001\n");
    send_item(8'h80, 1'b1);

    // Random files. Idling is switched per file so that there are also stretches
    // with none, and is off for the last part of the run.
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET * 85 / 100) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end else begin
        sender_gaps   = ($urandom_range(0, 3) != 0);
        receiver_gaps = ($urandom_range(0, 3) != 0);
      end
      if (files_sent == 2) begin
        // The receiver stops for a long time while clean data records keep coming,
        // so the block backs up and has to stall its input.
        squeeze_request = 1'b1;
        sender_gaps     = 1'b0;
        repeat (3) begin
          build_record(8'h00, 40, FLAW_NONE);
          send_line(1'b1);
        end
        send_item(8'h00, 1'b1);
        files_sent++;
      end else if (files_sent == 5) begin
        // The sender pauses until every pending result has been delivered.
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
        send_file();
      end else begin
        send_file();
      end
    end

    in_valid <= 1'b0;
    wait (outstanding == 0);
    // Give stray results room to show up before the verdict.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
